@@ hw/rtl/sdc_pkg.sv @@
// Shared constants, types and the tanh table for the stereo distortion clipper.
`default_nettype none

package sdc_pkg;

   // Sample and table geometry
   localparam int SAMPLE_BITS      = 24;
   localparam int TANH_TABLE_DEPTH = 256;

   // Gains and drive are unsigned Q4.12
   localparam int GAIN_W     = 16;
   localparam int GAIN_SHIFT = 12;
   localparam int GAIN_HALF  = 1 << (GAIN_SHIFT - 1);
   localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << GAIN_SHIFT);

   // Table covers magnitudes 0 .. 8.0, i.e. b below 2^SPAN_SHIFT
   localparam int SPAN_SHIFT = SAMPLE_BITS + 2;

   // Datapath widths, all magnitudes
   localparam int MAG_W  = SAMPLE_BITS;             // |x| up to 2^(SB-1)
   localparam int PA_W   = MAG_W + GAIN_W;          // |x| * input_gain
   localparam int A_W    = SAMPLE_BITS + 3;         // after input gain
   localparam int PB_W   = A_W + GAIN_W;            // a * drive
   localparam int B_W    = SAMPLE_BITS + 7;         // after drive
   localparam int IDX_W  = $clog2(TANH_TABLE_DEPTH);
   localparam int P_W    = SPAN_SHIFT + IDX_W;      // b * depth
   localparam int ROM_AW = $clog2(TANH_TABLE_DEPTH + 1);
   localparam int PI_W   = SAMPLE_BITS + SPAN_SHIFT; // slope * fraction
   localparam int N_W    = SAMPLE_BITS + GAIN_SHIFT; // dividend c << 12 plus half
   localparam int DIV_STAGES = (N_W + 1) / 2;       // two quotient bits per stage
   localparam int WORK_W = 2 * DIV_STAGES;
   localparam int PE_W   = WORK_W + GAIN_W;         // d * output_gain
   localparam int E_W    = PE_W - GAIN_SHIFT;

   // Register stages of one lane: six front stages, divider entry plus
   // DIV_STAGES divider stages, output gain product, saturation.
   localparam int PIPE_DEPTH = DIV_STAGES + 9;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_GAIN  = 2'd0,
      CSR_OUTPUT_GAIN = 2'd1,
      CSR_DRIVE       = 2'd2,
      CSR_CLIP_MODE   = 2'd3
   } csr_index_type;

   // Configuration as seen by the lanes (drive already forced nonzero)
   typedef struct packed {
      logic [GAIN_W-1:0] input_gain;
      logic [GAIN_W-1:0] output_gain;
      logic [GAIN_W-1:0] drive;
      logic              clip_mode;
   } sdc_cfg_type;

   typedef logic [TANH_TABLE_DEPTH:0][SAMPLE_BITS-1:0] tanh_rom_type;

   // Shift-and-subtract long division, used only while building the table
   function automatic logic [63:0] const_quotient(input logic [63:0] num,
                                                  input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(8*i/depth) in Q.(SB-1), built as (1-E)/(1+E) with E = r^i in Q.31,
   // r = exp(-16/depth) from a Taylor series in Q.40. Evaluated at elaboration.
   function automatic tanh_rom_type build_tanh_rom();
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  r;
      logic [63:0]  e;
      logic [63:0]  num;
      logic [63:0]  den;
      logic [63:0]  q;
      tanh_rom_type rom;
      term = 64'd1 << 40;
      sum  = term;
      // once the term reaches zero it stays zero, so no early exit is needed
      for (int k = 1; k <= 60; k++) begin
         term = const_quotient(term * 64'd16, 64'(TANH_TABLE_DEPTH) * 64'(k));
         if ((k & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = (sum + 64'd256) >> 9;
      e = 64'd1 << 31;
      rom[0] = '0;
      for (int k = 1; k <= TANH_TABLE_DEPTH; k++) begin
         e   = (e * r + (64'd1 << 30)) >> 31;
         num = ((64'd1 << 31) - e) << (SAMPLE_BITS - 1);
         den = (64'd1 << 31) + e;
         q   = const_quotient(num + (den >> 1), den);
         rom[k] = q[SAMPLE_BITS-1:0];
      end
      return rom;
   endfunction

   localparam tanh_rom_type TANH_ROM = build_tanh_rom();

endpackage

`default_nettype wire

@@ hw/rtl/sdc_req_if.sv @@
// Input stream interface: one stereo sample pair per transaction.
`default_nettype none

interface sdc_req_if import sdc_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sdc_rsp_if.sv @@
// Result stream interface: one processed stereo sample pair per transaction.
`default_nettype none

interface sdc_rsp_if import sdc_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sdc_lane.sv @@
// One channel datapath: gain, drive, clip, pipelined divide by drive, output gain.
`default_nettype none

module sdc_lane import sdc_pkg::*; (
   input  logic                          clock,
   input  logic                          en,
   input  sdc_cfg_type                   cfg,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] sample_out
);

   typedef struct packed {
      logic [GAIN_W-1:0] rem;
      logic [WORK_W-1:0] work;
   } div_state_type;

   // One restoring step: dividend bits leave the top of work, quotient bits enter below
   function automatic div_state_type div_step(div_state_type s, logic [GAIN_W-1:0] d);
      logic [GAIN_W:0] trial;
      div_state_type   r;
      trial = {s.rem, s.work[WORK_W-1]};
      if (trial >= {1'b0, d}) begin
         r.rem  = GAIN_W'(trial - {1'b0, d});
         r.work = {s.work[WORK_W-2:0], 1'b1};
      end else begin
         r.rem  = trial[GAIN_W-1:0];
         r.work = {s.work[WORK_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // Stage 1: sign and magnitude
   logic [MAG_W-1:0] mag_s1_in, mag_s1_ff;
   logic             neg_s1_in, neg_s1_ff;

   assign neg_s1_in = sample_in[SAMPLE_BITS-1];
   assign mag_s1_in = neg_s1_in ? (MAG_W'(0) - MAG_W'($unsigned(sample_in)))
                                : MAG_W'($unsigned(sample_in));

   // Stage 2: input gain product
   logic [PA_W-1:0] prod_a_s2_in, prod_a_s2_ff;
   logic            neg_s2_ff;

   assign prod_a_s2_in = PA_W'(mag_s1_ff) * PA_W'(cfg.input_gain);

   // Stage 3: round, then drive product
   logic [A_W-1:0]  a_val;
   logic [PB_W-1:0] prod_b_s3_in, prod_b_s3_ff;
   logic            neg_s3_ff;

   assign a_val        = A_W'((prod_a_s2_ff + PA_W'(GAIN_HALF)) >> GAIN_SHIFT);
   assign prod_b_s3_in = PB_W'(a_val) * PB_W'(cfg.drive);

   // Stage 4: round to the driven magnitude
   logic [B_W-1:0] b_s4_in, b_s4_ff;
   logic           neg_s4_ff;

   assign b_s4_in = B_W'((prod_b_s3_ff + PB_W'(GAIN_HALF)) >> GAIN_SHIFT);

   // Stage 5: table lookup for soft clip, clamp for hard clip
   logic [P_W-1:0]         tab_pos;
   logic [ROM_AW-1:0]      lo_idx;
   logic [ROM_AW-1:0]      hi_idx;
   logic [SAMPLE_BITS-1:0] lo_val;
   logic [SAMPLE_BITS-1:0] hi_val;
   logic [SAMPLE_BITS-1:0] lo_s5_in, lo_s5_ff;
   logic [SAMPLE_BITS-1:0] diff_s5_in, diff_s5_ff;
   logic [SPAN_SHIFT-1:0]  frac_s5_in, frac_s5_ff;
   logic                   sat_s5_in, sat_s5_ff;
   logic [SAMPLE_BITS-1:0] hard_s5_in, hard_s5_ff;
   logic                   neg_s5_ff;

   assign tab_pos    = P_W'(b_s4_ff[SPAN_SHIFT-1:0]) * P_W'(TANH_TABLE_DEPTH);
   assign lo_idx     = ROM_AW'(tab_pos[P_W-1:SPAN_SHIFT]);
   assign hi_idx     = lo_idx + ROM_AW'(1);
   assign lo_val     = TANH_ROM[lo_idx];
   assign hi_val     = TANH_ROM[hi_idx];
   assign lo_s5_in   = lo_val;
   assign diff_s5_in = (hi_val < lo_val) ? '0 : (hi_val - lo_val);
   assign frac_s5_in = tab_pos[SPAN_SHIFT-1:0];
   // at or beyond 8.0 the last table entry stands
   assign sat_s5_in  = (b_s4_ff >> SPAN_SHIFT) != '0;
   assign hard_s5_in = (b_s4_ff > B_W'(SAMPLE_ONE)) ? SAMPLE_ONE
                                                    : b_s4_ff[SAMPLE_BITS-1:0];

   // Stage 6: interpolation product
   logic [PI_W-1:0]        prod_i_s6_in, prod_i_s6_ff;
   logic [SAMPLE_BITS-1:0] lo_s6_ff;
   logic                   sat_s6_ff;
   logic [SAMPLE_BITS-1:0] hard_s6_ff;
   logic                   neg_s6_ff;

   assign prod_i_s6_in = PI_W'(diff_s5_ff) * PI_W'(frac_s5_ff);

   // Divider entry: select clipped value, form rounded dividend
   logic [SAMPLE_BITS-1:0] interp_inc;
   logic [SAMPLE_BITS-1:0] soft_val;
   logic [SAMPLE_BITS-1:0] clip_val;
   logic [N_W-1:0]         dividend;
   div_state_type          div0_in;
   div_state_type          div_ff  [0:DIV_STAGES];
   div_state_type          div_in  [1:DIV_STAGES];
   logic                   div_neg_ff [0:DIV_STAGES];

   assign interp_inc = SAMPLE_BITS'((prod_i_s6_ff + (PI_W'(1) << (SPAN_SHIFT - 1)))
                                    >> SPAN_SHIFT);
   assign soft_val   = sat_s6_ff ? TANH_ROM[TANH_TABLE_DEPTH] : (lo_s6_ff + interp_inc);
   assign clip_val   = cfg.clip_mode ? soft_val : hard_s6_ff;
   assign dividend   = (N_W'(clip_val) << GAIN_SHIFT) + N_W'(cfg.drive >> 1);
   assign div0_in.rem  = '0;
   assign div0_in.work = WORK_W'(dividend);

   // Divider stages, two quotient bits each
   always_comb begin
      for (int g = 1; g <= DIV_STAGES; g++) begin
         div_in[g] = div_step(div_step(div_ff[g-1], cfg.drive), cfg.drive);
      end
   end

   // Output gain product
   logic [PE_W-1:0] prod_e_in, prod_e_ff;
   logic            neg_m_ff;

   assign prod_e_in = PE_W'(div_ff[DIV_STAGES].work) * PE_W'(cfg.output_gain);

   // Final stage: round, restore sign, saturate
   logic [E_W-1:0]         e_val;
   logic [SAMPLE_BITS-1:0] neg_mag;
   logic [SAMPLE_BITS-1:0] result_in, result_ff;

   assign e_val   = E_W'((prod_e_ff + PE_W'(GAIN_HALF)) >> GAIN_SHIFT);
   assign neg_mag = (e_val > E_W'(SAMPLE_ONE)) ? SAMPLE_ONE : e_val[SAMPLE_BITS-1:0];
   assign result_in = neg_m_ff ? (SAMPLE_BITS'(0) - neg_mag)
                    : ((e_val > E_W'(SAMPLE_MAX)) ? SAMPLE_MAX : e_val[SAMPLE_BITS-1:0]);

   assign sample_out = $signed(result_ff);

   // Pipeline registers, all advance together
   always_ff @(posedge clock) begin
      if (en) begin
         mag_s1_ff    <= mag_s1_in;
         neg_s1_ff    <= neg_s1_in;
         prod_a_s2_ff <= prod_a_s2_in;
         neg_s2_ff    <= neg_s1_ff;
         prod_b_s3_ff <= prod_b_s3_in;
         neg_s3_ff    <= neg_s2_ff;
         b_s4_ff      <= b_s4_in;
         neg_s4_ff    <= neg_s3_ff;
         lo_s5_ff     <= lo_s5_in;
         diff_s5_ff   <= diff_s5_in;
         frac_s5_ff   <= frac_s5_in;
         sat_s5_ff    <= sat_s5_in;
         hard_s5_ff   <= hard_s5_in;
         neg_s5_ff    <= neg_s4_ff;
         prod_i_s6_ff <= prod_i_s6_in;
         lo_s6_ff     <= lo_s5_ff;
         sat_s6_ff    <= sat_s5_ff;
         hard_s6_ff   <= hard_s5_ff;
         neg_s6_ff    <= neg_s5_ff;
         div_ff[0]     <= div0_in;
         div_neg_ff[0] <= neg_s6_ff;
         for (int g = 1; g <= DIV_STAGES; g++) begin
            div_ff[g]     <= div_in[g];
            div_neg_ff[g] <= div_neg_ff[g-1];
         end
         prod_e_ff <= prod_e_in;
         neg_m_ff  <= div_neg_ff[DIV_STAGES];
         result_ff <= result_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/stereo_distortion_clipper.sv @@
// Top level of the stereo distortion clipper: config registers, valid pipeline, output skid.
//
//  Channel | Direction | Fields                              | Handshake
//  --------+-----------+-------------------------------------+------------------------
//  req     | in        | left_in, right_in  (signed Q1.23)   | valid / ready
//  rsp     | out       | left_out, right_out (signed Q1.23)  | valid / ready
//  csr     | in        | csr_index, csr_wr_data               | csr_wr_en, no back-pressure
//
//  One stereo pair per cycle while skid slot1 is free; the pipeline depth is set mostly
//  by the divide by drive, two quotient bits per stage.
//  Synchronous active-high reset clears the pipeline and skid valid bits and
//  loads the registers with unity gains, unity drive and hard clipping.
//  A two-entry output skid keeps taking transactions while one result waits;
//  the whole pipeline holds only when both slots are full.
`default_nettype none

module stereo_distortion_clipper import sdc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wr_data,
   sdc_req_if.sink              req,
   sdc_rsp_if.source            rsp
);

   // Configuration registers
   logic [GAIN_W-1:0] input_gain_ff;
   logic [GAIN_W-1:0] output_gain_ff;
   logic [GAIN_W-1:0] drive_ff;
   logic              clip_mode_ff;
   sdc_cfg_type       cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_gain_ff  <= GAIN_UNITY;
         output_gain_ff <= GAIN_UNITY;
         drive_ff       <= GAIN_UNITY;
         clip_mode_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_INPUT_GAIN:  input_gain_ff  <= csr_wr_data;
            CSR_OUTPUT_GAIN: output_gain_ff <= csr_wr_data;
            // zero drive acts as one LSB so the reciprocal exists
            CSR_DRIVE:       drive_ff <= (csr_wr_data == '0) ? GAIN_W'(1) : csr_wr_data;
            CSR_CLIP_MODE:   clip_mode_ff <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.input_gain  = input_gain_ff;
   assign cfg.output_gain = output_gain_ff;
   assign cfg.drive       = drive_ff;
   assign cfg.clip_mode   = clip_mode_ff;

   // Pipeline advance and valid bits
   logic                  pipe_en;
   logic [PIPE_DEPTH-1:0] pipe_valid_ff;
   logic                  slot0_valid_ff, slot0_valid_in;
   logic                  slot1_valid_ff, slot1_valid_in;

   assign pipe_en   = !slot1_valid_ff;
   assign req.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= '0;
      end else if (pipe_en) begin
         pipe_valid_ff <= {pipe_valid_ff[PIPE_DEPTH-2:0], req.valid};
      end
   end

   // Datapath lanes
   logic signed [SAMPLE_BITS-1:0] left_res;
   logic signed [SAMPLE_BITS-1:0] right_res;

   sdc_lane u_left (
      .clock      (clock),
      .en         (pipe_en),
      .cfg        (cfg),
      .sample_in  (req.left_in),
      .sample_out (left_res)
   );

   sdc_lane u_right (
      .clock      (clock),
      .en         (pipe_en),
      .cfg        (cfg),
      .sample_in  (req.right_in),
      .sample_out (right_res)
   );

   // Output skid, slot0 faces the consumer
   logic [2*SAMPLE_BITS-1:0] slot0_ff, slot0_in;
   logic [2*SAMPLE_BITS-1:0] slot1_ff, slot1_in;
   logic [2*SAMPLE_BITS-1:0] new_pair;
   logic                     push;
   logic                     pop;

   assign new_pair = {left_res, right_res};
   assign push     = pipe_en && pipe_valid_ff[PIPE_DEPTH-1];
   assign pop      = slot0_valid_ff && rsp.ready;

   always_comb begin
      slot0_in       = slot0_ff;
      slot1_in       = slot1_ff;
      slot0_valid_in = slot0_valid_ff;
      slot1_valid_in = slot1_valid_ff;
      if (!slot0_valid_ff) begin
         if (push) begin
            slot0_in       = new_pair;
            slot0_valid_in = 1'b1;
         end
      end else if (!slot1_valid_ff) begin
         if (push && pop) begin
            slot0_in = new_pair;
         end else if (pop) begin
            slot0_valid_in = 1'b0;
         end else if (push) begin
            slot1_in       = new_pair;
            slot1_valid_in = 1'b1;
         end
      end else if (pop) begin
         slot0_in       = slot1_ff;
         slot1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_valid_ff <= 1'b0;
         slot1_valid_ff <= 1'b0;
      end else begin
         slot0_valid_ff <= slot0_valid_in;
         slot1_valid_ff <= slot1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp.valid     = slot0_valid_ff;
   assign rsp.left_out  = $signed(slot0_ff[2*SAMPLE_BITS-1:SAMPLE_BITS]);
   assign rsp.right_out = $signed(slot0_ff[SAMPLE_BITS-1:0]);

   // Skid fills from slot0 upward
   assert property (@(posedge clock) disable iff (reset)
      slot1_valid_ff |-> slot0_valid_ff)
      else $error("skid slot1 holds a result while slot0 is empty");

   // A stall freezes every in-flight transaction
   assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(pipe_valid_ff))
      else $error("pipeline valid bits moved during a stall");

   // Draining a full skid moves the waiting result forward
   assert property (@(posedge clock) disable iff (reset)
      (slot0_valid_ff && slot1_valid_ff && rsp.ready) |=> (slot0_ff == $past(slot1_ff)))
      else $error("skid lost the waiting result");

endmodule

`default_nettype wire

@@ dv/sdc_clipper_checker.sv @@
// Checker for the stereo distortion clipper: predicts each sample pair and compares results.
`timescale 1ns / 100ps

module sdc_clipper_checker import sdc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wr_data,
   sdc_req_if                   req,
   sdc_rsp_if                   rsp,
   output int                   mismatch_count,
   output int                   pending_count
);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
   } stereo_pair_type;

   localparam logic [63:0] FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);
   localparam logic [63:0] WORD_MOD   = 64'd1 << SAMPLE_BITS;
   localparam logic [63:0] TABLE_SPAN = 64'd1 << SPAN_SHIFT;
   localparam logic [63:0] ROUND_HALF = 64'(GAIN_HALF);

   // Shadow copy of the configuration registers
   logic [GAIN_W-1:0] gain_in;
   logic [GAIN_W-1:0] gain_out;
   logic [GAIN_W-1:0] drive_reg;
   logic              soft_mode;

   logic [63:0]     tanh_points [0:TANH_TABLE_DEPTH];
   stereo_pair_type expected_pairs [$];

   // tanh breakpoints: (1-E)/(1+E), E = r^i in Q.31, r = exp(-16/depth) via Taylor in Q.40
   initial begin : build_tanh_points
      logic [63:0] term;
      logic [63:0] series;
      logic [63:0] ratio;
      logic [63:0] decay;
      logic [63:0] numer;
      logic [63:0] denom;
      term   = 64'd1 << 40;
      series = term;
      for (int k = 1; k <= 60; k++) begin
         term = (term * 64'd16) / (64'(TANH_TABLE_DEPTH) * 64'(k));
         if (k % 2 == 1) begin
            series = series - term;
         end else begin
            series = series + term;
         end
      end
      ratio = (series + 64'd256) >> 9;
      decay = 64'd1 << 31;
      tanh_points[0] = 64'd0;
      for (int i = 1; i <= TANH_TABLE_DEPTH; i++) begin
         decay = (decay * ratio + (64'd1 << 30)) >> 31;
         numer = ((64'd1 << 31) - decay) << (SAMPLE_BITS - 1);
         denom = (64'd1 << 31) + decay;
         tanh_points[i] = (numer + denom / 64'd2) / denom;
      end
   end

   // One channel: sign-magnitude gain, drive, clip, undo drive, output gain, saturate
   function automatic logic [SAMPLE_BITS-1:0] clip_sample(input logic [SAMPLE_BITS-1:0] raw);
      logic        negative;
      logic [63:0] mag;
      logic [63:0] drv;
      logic [63:0] gained;
      logic [63:0] driven;
      logic [63:0] clipped;
      logic [63:0] undriven;
      logic [63:0] level;
      logic [63:0] pos;
      logic [63:0] seg;
      logic [63:0] frac;
      logic [63:0] lo;
      logic [63:0] hi;
      negative = raw[SAMPLE_BITS-1];
      mag      = negative ? (WORD_MOD - 64'(raw)) : 64'(raw);
      // zero drive acts as one LSB
      drv      = (drive_reg == '0) ? 64'd1 : 64'(drive_reg);
      gained   = (mag * 64'(gain_in) + ROUND_HALF) >> GAIN_SHIFT;
      driven   = (gained * drv + ROUND_HALF) >> GAIN_SHIFT;
      if (soft_mode) begin
         if (driven >= TABLE_SPAN) begin
            // at or beyond 8.0: last table entry
            clipped = tanh_points[TANH_TABLE_DEPTH];
         end else begin
            pos  = driven * 64'(TANH_TABLE_DEPTH);
            seg  = pos >> SPAN_SHIFT;
            frac = pos & (TABLE_SPAN - 64'd1);
            lo   = tanh_points[seg];
            hi   = tanh_points[seg + 64'd1];
            if (hi < lo) begin
               hi = lo;
            end
            clipped = lo + (((hi - lo) * frac + (TABLE_SPAN >> 1)) >> SPAN_SHIFT);
         end
      end else begin
         clipped = (driven > FULL_SCALE) ? FULL_SCALE : driven;
      end
      undriven = ((clipped << GAIN_SHIFT) + drv / 64'd2) / drv;
      level    = (undriven * 64'(gain_out) + ROUND_HALF) >> GAIN_SHIFT;
      if (negative) begin
         if (level > FULL_SCALE) begin
            level = FULL_SCALE;
         end
         level = WORD_MOD - level;
      end else if (level > FULL_SCALE - 64'd1) begin
         level = FULL_SCALE - 64'd1;
      end
      return level[SAMPLE_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [SAMPLE_BITS-1:0] got,
                                  input logic [SAMPLE_BITS-1:0] want);
      mismatch_count++;
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Watch both channels and the register port at every edge
   always @(posedge clock) begin
      stereo_pair_type want;
      if (reset) begin
         gain_in        = GAIN_UNITY;
         gain_out       = GAIN_UNITY;
         drive_reg      = GAIN_UNITY;
         soft_mode      = 1'b0;
         mismatch_count = 0;
         expected_pairs.delete();
      end else begin
         // result transaction against the oldest expectation
         if (rsp.valid && rsp.ready) begin
            if (expected_pairs.size() == 0) begin
               report_mismatch("unexpected result left_out", rsp.left_out, '0);
            end else begin
               want = expected_pairs.pop_front();
               if (rsp.left_out !== want.left) begin
                  report_mismatch("left_out", rsp.left_out, want.left);
               end
               if (rsp.right_out !== want.right) begin
                  report_mismatch("right_out", rsp.right_out, want.right);
               end
            end
         end
         // input transaction
         if (req.valid && req.ready) begin
            want.left  = clip_sample(req.left_in);
            want.right = clip_sample(req.right_in);
            expected_pairs.push_back(want);
         end
         // register write
         if (csr_wr_en) begin
            case (csr_index)
               CSR_INPUT_GAIN:  gain_in   = csr_wr_data;
               CSR_OUTPUT_GAIN: gain_out  = csr_wr_data;
               CSR_DRIVE:       drive_reg = csr_wr_data;
               CSR_CLIP_MODE:   soft_mode = csr_wr_data[0];
               default: ;
            endcase
         end
      end
      pending_count <= expected_pairs.size();
   end

endmodule

@@ dv/tb_stereo_distortion_clipper.sv @@
// Testbench top for the stereo distortion clipper: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_stereo_distortion_clipper;
   import sdc_pkg::*;

   localparam int NUM_PHASES       = 12;
   localparam int RANDOM_PER_PHASE = 158;
   localparam int NUM_EDGE_PAIRS   = 12;
   localparam int WATCHDOG_LIMIT   = 5000;

   // Directed pairs: full-scale, one LSB, halves, alternating bit patterns
   localparam logic [SAMPLE_BITS-1:0] EDGE_LEFT [NUM_EDGE_PAIRS] = '{
      24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001, 24'hFFFFFF, 24'h400000,
      24'h7FF000, 24'h555555, 24'h000800, 24'h100000, 24'h123456, 24'h800001};
   localparam logic [SAMPLE_BITS-1:0] EDGE_RIGHT [NUM_EDGE_PAIRS] = '{
      24'h000000, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000001, 24'hC00000,
      24'h800100, 24'hAAAAAA, 24'hFFF800, 24'h080000, 24'hEDCBAA, 24'h7FFFFE};

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0]    csr_wr_data;

   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int pending;
   int quiet_cycles = 0;

   sdc_req_if req_ch ();
   sdc_rsp_if rsp_ch ();

   stereo_distortion_clipper dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   sdc_clipper_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_stereo_distortion_clipper: errors");
            $finish;
         end
      end
   end

   // Mix of full-range, small-magnitude and near-full-scale samples
   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      logic [SAMPLE_BITS-1:0] v;
      case ($urandom_range(3))
         0: begin
            v = SAMPLE_BITS'($urandom_range(65535));
            if ($urandom_range(1) == 1) begin
               v = -v;
            end
         end
         1: begin
            if ($urandom_range(1) == 1) begin
               v = SAMPLE_ONE + SAMPLE_BITS'($urandom_range(255));
            end else begin
               v = SAMPLE_MAX - SAMPLE_BITS'($urandom_range(255));
            end
         end
         default: v = SAMPLE_BITS'($urandom());
      endcase
      return v;
   endfunction

   // One input transaction, with random idle cycles ahead of it
   task automatic send_pair(input logic [SAMPLE_BITS-1:0] left, input logic [SAMPLE_BITS-1:0] right);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.left_in  <= left;
      req_ch.right_in <= right;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // Stop sending and wait for every expected result
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
   endtask

   // Write all four registers; clip mode carries random upper bits that must be ignored
   task automatic apply_settings(input logic [GAIN_W-1:0] ig, input logic [GAIN_W-1:0] og,
                                 input logic [GAIN_W-1:0] drv, input logic mode);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_INPUT_GAIN;
      csr_wr_data <= ig;
      @(posedge clock);
      csr_index   <= CSR_OUTPUT_GAIN;
      csr_wr_data <= og;
      @(posedge clock);
      csr_index   <= CSR_DRIVE;
      csr_wr_data <= drv;
      @(posedge clock);
      csr_index   <= CSR_CLIP_MODE;
      csr_wr_data <= (GAIN_W'($urandom_range(32767)) << 1) | GAIN_W'(mode);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      logic [GAIN_W-1:0] ig;
      logic [GAIN_W-1:0] og;
      logic [GAIN_W-1:0] drv;
      logic              mode;
      req_ch.valid    <= 1'b0;
      req_ch.left_in  <= '0;
      req_ch.right_in <= '0;
      csr_wr_en       <= 1'b0;
      csr_index       <= CSR_INPUT_GAIN;
      csr_wr_data     <= '0;
      reset           <= 1'b1;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // idle pattern rotates: none, sender, receiver, both
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase

         // phase 0 runs on reset values; later phases reprogram while idle
         if (phase > 0) begin
            drain();
            case (phase)
               1: begin ig = 16'd4096;  og = 16'd4096;  drv = 16'd4096;  mode = 1'b1; end
               2: begin ig = 16'd65535; og = 16'd65535; drv = 16'd65535; mode = 1'b1; end
               3: begin ig = 16'd0;     og = 16'd65535; drv = 16'd4096;  mode = 1'b0; end
               4: begin ig = 16'd65535; og = 16'd4096;  drv = 16'd1;     mode = 1'b0; end
               5: begin ig = 16'd8192;  og = 16'd4096;  drv = 16'd0;     mode = 1'b1; end
               6: begin ig = 16'd4096;  og = 16'd0;     drv = 16'd65535; mode = 1'b0; end
               default: begin
                  ig   = ($urandom_range(1) == 1) ? GAIN_W'($urandom_range(65535))
                                                  : GAIN_W'($urandom_range(1024, 16384));
                  og   = ($urandom_range(1) == 1) ? GAIN_W'($urandom_range(65535))
                                                  : GAIN_W'($urandom_range(1024, 16384));
                  drv  = ($urandom_range(1) == 1) ? GAIN_W'($urandom_range(65535))
                                                  : GAIN_W'($urandom_range(8192));
                  mode = 1'($urandom_range(1));
               end
            endcase
            apply_settings(ig, og, drv, mode);
         end

         // directed pairs under hard unity and under maximum soft drive
         if (phase == 0 || phase == 2) begin
            for (int i = 0; i < NUM_EDGE_PAIRS; i++) begin
               send_pair(EDGE_LEFT[i], EDGE_RIGHT[i]);
            end
         end

         repeat (RANDOM_PER_PHASE) begin
            send_pair(random_sample(), random_sample());
         end
      end

      drain();
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_stereo_distortion_clipper: clean");
      end else begin
         $display("tb_stereo_distortion_clipper: errors");
      end
      $finish;
   end

endmodule
